>>> sv/doi_pkg.sv
`timescale 1ns / 1ps

package doi_pkg;

  // Working width for accelerations, RK4 sums and quotients
  localparam int WIDE_W = 48;
  // Quotient bits resolved per cycle in the divider
  localparam int DIV_RADIX_BITS = 8;
  localparam int RK4_DIVISOR = 6;
  localparam int FRAC_SHIFT = 27;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [31:0] q28_t;
  typedef logic signed [63:0] prod_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [1:0] mode_t;

  localparam cfg_idx_t CFG_SPRING = 2'd0;
  localparam cfg_idx_t CFG_DAMPING = 2'd1;
  localparam cfg_idx_t CFG_MODE = 2'd2;

  localparam mode_t MODE_SEMI = 2'd0;
  localparam mode_t MODE_EULER = 2'd1;
  localparam mode_t MODE_RK4 = 2'd2;

  localparam wide_t Q28_MAX = wide_t'(32'sh7FFF_FFFF);
  localparam wide_t Q28_MIN = wide_t'(32'sh8000_0000);
  localparam prod_t ROUND_BIAS = prod_t'(64'sd67108864);

  function automatic wide_t ext_q28(input q28_t a);
    return wide_t'(a);
  endfunction

  function automatic q28_t sat_q28(input wide_t a);
    q28_t r;
    if (a > Q28_MAX) begin
      r = Q28_MAX[31:0];
    end else if (a < Q28_MIN) begin
      r = Q28_MIN[31:0];
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // Q5.27 x Q4.28 product back to Q4.28, round half up
  function automatic wide_t rnd_q28(input prod_t p);
    prod_t t;
    t = p + ROUND_BIAS;
    return wide_t'(t >>> FRAC_SHIFT);
  endfunction

  function automatic wide_t half_up(input wide_t a);
    wide_t t;
    t = a + wide_t'(1);
    return t >>> 1;
  endfunction

endpackage

>>> sv/doi_rdiv.sv
`timescale 1ns / 1ps

module doi_rdiv import doi_pkg::*; #(
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  wide_t            dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output wide_t            quotient
);

  localparam int GROUPS = WIDE_W / DIV_RADIX_BITS;
  localparam int CNT_W = ($clog2(GROUPS) > 0) ? $clog2(GROUPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUPS - 1);

  logic              busy_r;
  logic              fin_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WIDE_W-1:0] work_r;
  logic [DVS_W-1:0]  rem_r;
  wide_t             quotient_r;

  logic [WIDE_W-1:0] work_nxt;
  logic [DVS_W-1:0]  rem_nxt;
  logic [WIDE_W-1:0] load_val;
  wide_t             mag;

  // Magnitude plus half the divisor: rounds to nearest, ties away from zero
  always_comb begin
    mag = dividend[WIDE_W-1] ? -dividend : dividend;
    load_val = mag + WIDE_W'(divisor >> 1);
  end

  // Restoring division, one group of quotient bits per cycle
  always_comb begin
    logic [DVS_W:0] r2;
    rem_nxt = rem_r;
    work_nxt = work_r;
    r2 = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      r2 = {rem_nxt, work_nxt[WIDE_W-1]};
      work_nxt = work_nxt << 1;
      if (r2 >= {1'b0, divisor}) begin
        r2 = r2 - {1'b0, divisor};
        work_nxt[0] = 1'b1;
      end
      rem_nxt = r2[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        work_r <= load_val;
        rem_r <= '0;
        neg_r <= dividend[WIDE_W-1];
      end else if (busy_r) begin
        work_r <= work_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r <= 1'b0;
        done_r <= 1'b1;
        quotient_r <= neg_r ? -$signed(work_r) : $signed(work_r);
      end
    end
  end

  assign done = done_r;
  assign quotient = quotient_r;

endmodule

>>> sv/damped_oscillator_integrator_top.sv
`timescale 1ns / 1ps

// Damped mass-spring oscillator, one output sample per input transfer. Position
// and velocity are signed Q4.28 and saturate; coefficients are unsigned Q5.27.
// One 33x32 multiplier forms the spring and damping products and one divider
// (8 quotient bits per cycle) handles the round-to-nearest divisions; a small
// sequencer reuses both. The block takes one item at a time: in_stall stays
// high from acceptance until the result is loaded into the output register,
// which then waits for the sink while the next item is taken. Euler mode runs
// EULER_SUBSTEPS substeps per item, each with two divider passes; RK4 mode
// runs its stages and then two divider passes; semi-implicit mode uses no
// divider. No clearing pass after reset.
module damped_oscillator_integrator_top import doi_pkg::*; #(
  parameter int EULER_SUBSTEPS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  q28_t        in_start_position,
  input  q28_t        in_start_velocity,
  output logic        out_valid,
  input  logic        out_stall,
  output q28_t        out_sample_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DVS_W = ($clog2(EULER_SUBSTEPS + 1) > 3) ? $clog2(EULER_SUBSTEPS + 1) : 3;
  localparam int SUB_CW = ($clog2(EULER_SUBSTEPS) > 0) ? $clog2(EULER_SUBSTEPS) : 1;
  localparam logic [DVS_W-1:0] DIVISOR_EULER = DVS_W'(EULER_SUBSTEPS);
  localparam logic [DVS_W-1:0] DIVISOR_RK4 = DVS_W'(RK4_DIVISOR);
  localparam logic [SUB_CW-1:0] SUB_LAST = SUB_CW'(EULER_SUBSTEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_MUL_K,
    ST_MUL_D,
    ST_ACC,
    ST_POST,
    ST_DIV_A,
    ST_WAIT_A,
    ST_DIV_B,
    ST_WAIT_B,
    ST_UPDATE,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [31:0]       spring_r;
  logic [31:0]       damping_r;
  mode_t             mode_r;
  q28_t              pos_r;
  q28_t              vel_r;
  q28_t              opx_r;
  q28_t              opv_r;
  prod_t             prod_r;
  wide_t             acc_r;
  wide_t             sx_r;
  wide_t             sv_r;
  wide_t             q1_r;
  logic [1:0]        stage_r;
  logic [SUB_CW-1:0] sub_cnt_r;
  logic              out_valid_r;
  q28_t              out_sample_r;

  logic signed [32:0] mul_a;
  q28_t               mul_b;
  logic signed [64:0] mul_full;
  q28_t               semi_x;
  wide_t              step_x;
  wide_t              step_v;
  q28_t               rk_nx;
  q28_t               rk_nv;
  logic               rk_mid;
  wide_t              sx_add;
  wide_t              sv_add;
  logic               is_rk4;
  logic               div_start;
  wide_t              div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  wide_t              div_q;

  assign is_rk4 = (mode_r == MODE_RK4);

  // Shared multiplier: spring term in ST_MUL_K, damping term otherwise
  always_comb begin
    mul_a = $signed({1'b0, (state_r == ST_MUL_K) ? spring_r : damping_r});
    mul_b = (state_r == ST_MUL_K) ? opx_r : opv_r;
    mul_full = mul_a * mul_b;
  end

  assign semi_x = sat_q28(ext_q28(pos_r) + ext_q28(vel_r));

  // RK4 stage state and weighted sums
  always_comb begin
    rk_mid = (stage_r == 2'd1) || (stage_r == 2'd2);
    step_x = (stage_r == 2'd2) ? ext_q28(opv_r) : half_up(ext_q28(opv_r));
    step_v = (stage_r == 2'd2) ? acc_r : half_up(acc_r);
    rk_nx = sat_q28(ext_q28(pos_r) + step_x);
    rk_nv = sat_q28(ext_q28(vel_r) + step_v);
    sx_add = rk_mid ? (ext_q28(opv_r) <<< 1) : ext_q28(opv_r);
    sv_add = rk_mid ? (acc_r <<< 1) : acc_r;
  end

  always_comb begin
    div_start = (state_r == ST_DIV_A) || (state_r == ST_DIV_B);
    div_divisor = is_rk4 ? DIVISOR_RK4 : DIVISOR_EULER;
    if (state_r == ST_DIV_A) begin
      div_dividend = is_rk4 ? sx_r : ext_q28(vel_r);
    end else begin
      div_dividend = is_rk4 ? sv_r : acc_r;
    end
  end

  doi_rdiv #(
    .DVS_W(DVS_W)
  ) u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      spring_r <= '0;
      damping_r <= '0;
      mode_r <= MODE_SEMI;
      pos_r <= '0;
      vel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SPRING:  spring_r <= cfg_data;
          CFG_DAMPING: damping_r <= cfg_data;
          CFG_MODE:    mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end

      // ST_DONE refills the output register on its own
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_func) begin
              pos_r <= in_start_position;
              vel_r <= in_start_velocity;
            end
            sub_cnt_r <= '0;
            state_r <= ST_BEGIN;
          end
        end
        ST_BEGIN: begin
          case (mode_r)
            MODE_EULER, MODE_RK4: begin
              opx_r <= pos_r;
              opv_r <= vel_r;
              sx_r <= '0;
              sv_r <= '0;
              stage_r <= 2'd0;
            end
            default: begin
              pos_r <= semi_x;
              opx_r <= semi_x;
              opv_r <= vel_r;
            end
          endcase
          state_r <= ST_MUL_K;
        end
        ST_MUL_K: begin
          prod_r <= mul_full[63:0];
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          acc_r <= -rnd_q28(prod_r);
          prod_r <= mul_full[63:0];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_r - rnd_q28(prod_r);
          state_r <= ST_POST;
        end
        ST_POST: begin
          case (mode_r)
            MODE_EULER: begin
              state_r <= ST_DIV_A;
            end
            MODE_RK4: begin
              sx_r <= sx_r + sx_add;
              sv_r <= sv_r + sv_add;
              if (stage_r == 2'd3) begin
                state_r <= ST_DIV_A;
              end else begin
                opx_r <= rk_nx;
                opv_r <= rk_nv;
                stage_r <= stage_r + 2'd1;
                state_r <= ST_MUL_K;
              end
            end
            default: begin
              vel_r <= sat_q28(ext_q28(vel_r) + acc_r);
              state_r <= ST_DONE;
            end
          endcase
        end
        ST_DIV_A: begin
          state_r <= ST_WAIT_A;
        end
        ST_WAIT_A: begin
          if (div_done) begin
            q1_r <= div_q;
            state_r <= ST_DIV_B;
          end
        end
        ST_DIV_B: begin
          state_r <= ST_WAIT_B;
        end
        ST_WAIT_B: begin
          if (div_done) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          pos_r <= sat_q28(ext_q28(pos_r) + q1_r);
          vel_r <= sat_q28(ext_q28(vel_r) + div_q);
          if (!is_rk4 && (sub_cnt_r != SUB_LAST)) begin
            sub_cnt_r <= sub_cnt_r + 1'b1;
            state_r <= ST_BEGIN;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_sample_r <= pos_r;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign cfg_ready = 1'b1;

endmodule
